>>> src/cbd_pkg.sv
// ----------------------------------------------------------------------------
// cbd_pkg
// Shared widths, register indexes and limits for the cell balance decider.
// ----------------------------------------------------------------------------
package cbd_pkg;

  localparam int IDX_W   = 4;
  localparam int VOLT_W  = 16;
  localparam int MASK_W  = 16;
  localparam int SUM_W   = 20;
  localparam int CNT_W   = 5;
  localparam int RATE_W  = 16;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int RIDX_W  = 3;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [RIDX_W-1:0] REG_CELL_MIN       = 3'd0;
  localparam logic [RIDX_W-1:0] REG_CELL_MAX       = 3'd1;
  localparam logic [RIDX_W-1:0] REG_OPEN_LOW       = 3'd2;
  localparam logic [RIDX_W-1:0] REG_OPEN_HIGH      = 3'd3;
  localparam logic [RIDX_W-1:0] REG_HYST_LOW       = 3'd4;
  localparam logic [RIDX_W-1:0] REG_TRICKLE_LOW    = 3'd5;
  localparam logic [RIDX_W-1:0] REG_TRICKLE_NORMAL = 3'd6;
  localparam logic [RIDX_W-1:0] REG_CELL_COUNT     = 3'd7;

  localparam logic [VOLT_W-1:0] RST_CELL_MIN       = 16'd3000;
  localparam logic [VOLT_W-1:0] RST_CELL_MAX       = 16'd4100;
  localparam logic [VOLT_W-1:0] RST_OPEN_LOW       = 16'd1000;
  localparam logic [VOLT_W-1:0] RST_OPEN_HIGH      = 16'd4500;
  localparam logic [VOLT_W-1:0] RST_HYST_LOW       = 16'd3900;
  localparam logic [RATE_W-1:0] RST_TRICKLE_LOW    = 16'd100;
  localparam logic [RATE_W-1:0] RST_TRICKLE_NORMAL = 16'd1000;
  localparam logic [CNT_W-1:0]  RST_CELL_COUNT     = 5'd16;

endpackage

>>> src/cbd_if.sv
// ----------------------------------------------------------------------------
// cbd_in_if / cbd_out_if
// Valid/ready channels for cell samples and pass results.
// ----------------------------------------------------------------------------
interface cbd_in_if;
  import cbd_pkg::*;

  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  cell_index;
  logic [VOLT_W-1:0] cell_voltage;
  logic              installed;
  logic              last_cell;

  modport source (output valid, cell_index, cell_voltage, installed, last_cell,
                  input ready);
  modport sink (input valid, cell_index, cell_voltage, installed, last_cell,
                output ready);
endinterface

interface cbd_out_if;
  import cbd_pkg::*;

  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] discharge_mask;
  logic [MASK_W-1:0] open_wire_mask;
  logic [SUM_W-1:0]  cell_sum;
  logic              dump_on;
  logic              ext_charger_on;
  logic [RATE_W-1:0] trickle_rate;
  logic              hysteresis_on;

  modport source (output valid, discharge_mask, open_wire_mask, cell_sum, dump_on,
                  ext_charger_on, trickle_rate, hysteresis_on, input ready);
  modport sink (input valid, discharge_mask, open_wire_mask, cell_sum, dump_on,
                ext_charger_on, trickle_rate, hysteresis_on, output ready);
endinterface

>>> src/cell_balance_decider.sv
// ----------------------------------------------------------------------------
// cell_balance_decider
// Classifies cell samples of a pass and issues balancing and charge decisions.
// ----------------------------------------------------------------------------
// One cell sample is taken per clock. A sample is held in an input register,
// then classified and folded into the pass state when it leaves that register;
// a sample marked last_cell loads the result register, so a result reaches the
// output through the input register and then the result register. The input
// side stalls only while a last-cell sample waits behind an untaken result.
// Configuration is an APB-style port with registers at 4-byte steps.
module cell_balance_decider #(
  parameter int NUM_CELLS = 16,
  parameter int VOLT_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  cbd_in_if.sink                     cell_in,
  cbd_out_if.source                  result_out,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cbd_pkg::ADDR_W-1:0] paddr,
  input  logic [cbd_pkg::DATA_W-1:0] pwdata,
  output logic [cbd_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import cbd_pkg::*;

  localparam int VW = (VOLT_BITS < VOLT_W) ? VOLT_BITS : VOLT_W;
  localparam int MW = (NUM_CELLS < MASK_W) ? NUM_CELLS : MASK_W;

  // configuration
  logic [VOLT_W-1:0] cell_min, cell_max, open_low, open_high, hyst_low;
  logic [RATE_W-1:0] trickle_low_rate, trickle_normal_rate;
  logic [CNT_W-1:0]  cell_count;
  logic [RIDX_W-1:0] reg_idx;
  logic              cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_min            <= RST_CELL_MIN;
      cell_max            <= RST_CELL_MAX;
      open_low            <= RST_OPEN_LOW;
      open_high           <= RST_OPEN_HIGH;
      hyst_low            <= RST_HYST_LOW;
      trickle_low_rate    <= RST_TRICKLE_LOW;
      trickle_normal_rate <= RST_TRICKLE_NORMAL;
      cell_count          <= RST_CELL_COUNT;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_CELL_MIN:       cell_min            <= pwdata[VOLT_W-1:0];
        REG_CELL_MAX:       cell_max            <= pwdata[VOLT_W-1:0];
        REG_OPEN_LOW:       open_low            <= pwdata[VOLT_W-1:0];
        REG_OPEN_HIGH:      open_high           <= pwdata[VOLT_W-1:0];
        REG_HYST_LOW:       hyst_low            <= pwdata[VOLT_W-1:0];
        REG_TRICKLE_LOW:    trickle_low_rate    <= pwdata[RATE_W-1:0];
        REG_TRICKLE_NORMAL: trickle_normal_rate <= pwdata[RATE_W-1:0];
        REG_CELL_COUNT:     cell_count          <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CELL_MIN:       prdata = DATA_W'(cell_min);
      REG_CELL_MAX:       prdata = DATA_W'(cell_max);
      REG_OPEN_LOW:       prdata = DATA_W'(open_low);
      REG_OPEN_HIGH:      prdata = DATA_W'(open_high);
      REG_HYST_LOW:       prdata = DATA_W'(hyst_low);
      REG_TRICKLE_LOW:    prdata = DATA_W'(trickle_low_rate);
      REG_TRICKLE_NORMAL: prdata = DATA_W'(trickle_normal_rate);
      REG_CELL_COUNT:     prdata = DATA_W'(cell_count);
      default:            prdata = '0;
    endcase
  end

  // input register
  logic              s1_valid;
  logic [IDX_W-1:0]  s1_idx;
  logic [VW-1:0]     s1_volt;
  logic              s1_inst;
  logic              s1_last;
  logic              s1_fire;
  logic              out_free;

  assign out_free      = !result_out.valid || result_out.ready;
  assign s1_fire       = s1_valid && (!s1_last || out_free);
  assign cell_in.ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cell_in.ready) begin
      s1_valid <= cell_in.valid;
    end
    if (cell_in.valid && cell_in.ready) begin
      s1_idx  <= cell_in.cell_index;
      s1_volt <= cell_in.cell_voltage[VW-1:0];
      s1_inst <= cell_in.installed;
      s1_last <= cell_in.last_cell;
    end
  end

  // pass state
  logic              hyst_flag, hyst_flag_next;
  logic [MW-1:0]     trip_mask, trip_mask_next;
  logic [MW-1:0]     pass_discharge, pass_discharge_next;
  logic [MW-1:0]     pass_open, pass_open_next;
  logic [MW-1:0]     pass_present, pass_present_next;
  logic [CNT_W-1:0]  over_count, over_count_next;
  logic [CNT_W-1:0]  under_count, under_count_next;
  logic [SUM_W-1:0]  sum_acc, sum_acc_next;

  logic [VOLT_W-1:0] v;
  logic [MW-1:0]     bit_sel;
  logic [SUM_W:0]    sum_wide;
  logic              in_use;
  logic              dump_next, ext_next;
  logic [RATE_W-1:0] trickle_next;

  always_comb begin
    v        = VOLT_W'(s1_volt);
    bit_sel  = MW'(1) << s1_idx;
    in_use   = s1_inst && (32'(s1_idx) < NUM_CELLS);
    sum_wide = {1'b0, sum_acc} + (SUM_W + 1)'(v);

    hyst_flag_next      = hyst_flag;
    trip_mask_next      = trip_mask;
    pass_discharge_next = pass_discharge;
    pass_open_next      = pass_open;
    pass_present_next   = pass_present;
    over_count_next     = over_count;
    under_count_next    = under_count;
    sum_acc_next        = sum_acc;

    if (in_use) begin
      pass_present_next = pass_present | bit_sel;
      sum_acc_next      = (sum_wide > (SUM_W + 1)'(SUM_MAX)) ? SUM_MAX
                                                              : sum_wide[SUM_W-1:0];
      if (v < cell_min) begin
        if (v < open_low) begin
          pass_open_next = pass_open | bit_sel;
        end else if (under_count != CNT_MAX) begin
          under_count_next = under_count + CNT_W'(1);
        end
      end else if (v < hyst_low) begin
        hyst_flag_next = 1'b0;
        trip_mask_next = '0;
      end else if (v > cell_max) begin
        if (v > open_high) begin
          pass_open_next = pass_open | bit_sel;
        end else begin
          if (over_count != CNT_MAX) begin
            over_count_next = over_count + CNT_W'(1);
          end
          pass_discharge_next = pass_discharge | bit_sel;
          trip_mask_next      = trip_mask | bit_sel;
        end
      end
    end

    if (s1_last && (pass_present_next == trip_mask_next)) begin
      hyst_flag_next = 1'b1;
    end

    dump_next    = 1'b0;
    ext_next     = 1'b0;
    trickle_next = '0;
    if (over_count_next == cell_count) begin
      dump_next = 1'b1;
    end else if (over_count_next == '0) begin
      if (under_count_next != '0) begin
        trickle_next = trickle_low_rate;
      end else if (!hyst_flag_next) begin
        trickle_next = trickle_normal_rate;
        ext_next     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hyst_flag      <= 1'b0;
      trip_mask      <= '0;
      pass_discharge <= '0;
      pass_open      <= '0;
      pass_present   <= '0;
      over_count     <= '0;
      under_count    <= '0;
      sum_acc        <= '0;
    end else if (s1_fire) begin
      hyst_flag <= hyst_flag_next;
      trip_mask <= trip_mask_next;
      if (s1_last) begin
        pass_discharge <= '0;
        pass_open      <= '0;
        pass_present   <= '0;
        over_count     <= '0;
        under_count    <= '0;
        sum_acc        <= '0;
      end else begin
        pass_discharge <= pass_discharge_next;
        pass_open      <= pass_open_next;
        pass_present   <= pass_present_next;
        over_count     <= over_count_next;
        under_count    <= under_count_next;
        sum_acc        <= sum_acc_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_out.valid <= 1'b0;
    end else if (s1_fire && s1_last) begin
      result_out.valid <= 1'b1;
    end else if (result_out.ready) begin
      result_out.valid <= 1'b0;
    end
    if (s1_fire && s1_last) begin
      result_out.discharge_mask <= MASK_W'(pass_discharge_next);
      result_out.open_wire_mask <= MASK_W'(pass_open_next);
      result_out.cell_sum       <= sum_acc_next;
      result_out.dump_on        <= dump_next;
      result_out.ext_charger_on <= ext_next;
      result_out.trickle_rate   <= trickle_next;
      result_out.hysteresis_on  <= hyst_flag_next;
    end
  end

  // checks
  a_dump_ext_exclusive: assert property (@(posedge clk) disable iff (rst)
    result_out.valid |-> !(result_out.dump_on && result_out.ext_charger_on))
    else $error("dump and external charger both on");

  a_ext_needs_relax: assert property (@(posedge clk) disable iff (rst)
    (result_out.valid && result_out.ext_charger_on) |->
      (!result_out.hysteresis_on && result_out.trickle_rate == trickle_normal_rate))
    else $error("external charger on outside normal charging");

  a_pass_cleared: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_last) |=>
      (sum_acc == '0 && over_count == '0 && under_count == '0 && pass_present == '0))
    else $error("pass state not cleared after last cell");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !cell_in.ready |-> (s1_valid && s1_last && result_out.valid && !result_out.ready))
    else $error("input stalled without a blocked result");

endmodule
